/* src/sawlc_pkg.sv */
// ============================================================================
// Cache package
// Sizes, derived widths, per-set metadata types and the sequencer state type.
// ============================================================================
package sawlc_pkg;

  localparam int unsigned WAYS            = 4;
  localparam int unsigned SETS            = 64;
  localparam int unsigned WORDS_PER_BLOCK = 8;
  localparam int unsigned MEM_BLOCKS      = 4096;

  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned OFF_W   = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
  localparam int unsigned BLK_W   = $clog2(MEM_BLOCKS);
  localparam int unsigned TAG_RAW = BLK_W - $clog2(SETS);
  localparam int unsigned TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int unsigned LINES   = SETS * WAYS;
  localparam int unsigned LINE_W  = $clog2(LINES) > 0 ? $clog2(LINES) : 1;
  localparam int unsigned LWORD_W = $clog2(LINES * WORDS_PER_BLOCK);
  localparam int unsigned MWORD_W = $clog2(MEM_BLOCKS * WORDS_PER_BLOCK);
  localparam int unsigned MEM_WORDS = MEM_BLOCKS * WORDS_PER_BLOCK;

  // Bookkeeping of one way: tag, valid, dirty and LRU rank.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic [WAY_W-1:0] rank;
  } way_meta_t;

  // Bookkeeping of a whole set, one word of the set memory.
  typedef way_meta_t [WAYS-1:0] set_meta_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WB,
    ST_FILL,
    ST_DONE
  } seq_state_t;

endpackage

/* src/sawlc_if.sv */
// ============================================================================
// Cache channel interfaces
// Valid and ready handshake channels for requests and results.
// ============================================================================
interface sawlc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [11:0] block_address;
  logic [2:0]  word_offset;
  logic [31:0] write_data;
  modport source (output valid, req_type, block_address, word_offset, write_data,
                  input ready);
  modport sink   (input valid, req_type, block_address, word_offset, write_data,
                  output ready);
endinterface

interface sawlc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] word_value;
  logic [1:0]  way_used;
  logic        wrote_back;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  modport source (output valid, hit, word_value, way_used, wrote_back, hit_total,
                  miss_total, input ready);
  modport sink   (input valid, hit, word_value, way_used, wrote_back, hit_total,
                  miss_total, output ready);
endinterface

/* src/set_assoc_writeback_lru_cache.sv */
// ============================================================================
// Set-associative write-back LRU cache
// Four-way cache with an internal backing store, valid/dirty/LRU per line.
// ============================================================================
// After reset the block sweeps the backing store once to zero it, one word a
// cycle, clearing the per-set bookkeeping memory in the same pass, and takes
// no request during it. A hit then goes through a set lookup, then the line
// word read and write, before the result. A miss adds a write-back of a dirty
// victim and a fill, each one word at a time, since the line and store
// memories have one port each. One request is worked on at a time, so the
// set bookkeeping written at the end of a lookup is always settled before the
// next request reads it; a new request is taken only once the previous
// result has been accepted.
module set_assoc_writeback_lru_cache (
  input logic clk,
  input logic rst_n,
  sawlc_req_if.sink   in_req,
  sawlc_rsp_if.source out_rsp
);
  import sawlc_pkg::*;

  seq_state_t state_r, state_nxt;

  // Memories: per-set bookkeeping, line words and backing store.
  set_meta_t         set_mem  [SETS];
  logic [31:0]       line_mem [LINES * WORDS_PER_BLOCK];
  logic [31:0]       back_mem [MEM_WORDS];

  // Request registers.
  logic              wr_r;
  logic [SET_W-1:0]  set_r;
  logic [TAG_W-1:0]  tag_r;
  logic [OFF_W-1:0]  off_r;
  logic [31:0]       wdata_r;
  logic [WAY_W-1:0]  way_r;
  logic              hit_r, wb_r;
  logic [TAG_W-1:0]  vtag_r;
  logic [OFF_W:0]    cnt_r;
  logic              rd_pend_r;
  logic [MWORD_W:0]  clr_r;
  logic [31:0]       hits_r, miss_r;

  // Memory read data.
  set_meta_t         meta_q;
  logic [31:0]       line_q, back_q;

  // Result register.
  logic              ovalid_r;
  logic              ohit_r, owb_r;
  logic [31:0]       oval_r;
  logic [1:0]        oway_r;

  logic accept;
  assign in_req.ready = (state_r == ST_IDLE) && !ovalid_r;
  assign accept = in_req.valid && in_req.ready;

  logic [BLK_W-1:0] blk_in;
  assign blk_in = in_req.block_address[BLK_W-1:0];

  // Lookup results from the set read.
  logic             hit_c;
  logic [WAY_W-1:0] hway_c, vway_c, uway_c;
  logic             vfound;
  logic             vdirty_c;
  always_comb begin
    hit_c  = 1'b0;
    hway_c = '0;
    vway_c = '0;
    vfound = 1'b0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (meta_q[i].valid && meta_q[i].tag == tag_r) begin
        hit_c  = 1'b1;
        hway_c = WAY_W'(i);
      end
      if (meta_q[i].rank == '0) begin
        vway_c = WAY_W'(i);
        vfound = 1'b1;
      end
    end
    if (!vfound) vway_c = '0;
  end
  assign uway_c   = hit_c ? hway_c : vway_c;
  assign vdirty_c = meta_q[vway_c].valid && meta_q[vway_c].dirty;

  // Updated set bookkeeping: LRU refresh, then tag, valid and dirty.
  set_meta_t meta_nxt;
  always_comb begin
    meta_nxt = meta_q;
    for (int i = 0; i < WAYS; i++)
      if (meta_q[i].rank > meta_q[uway_c].rank) meta_nxt[i].rank = meta_q[i].rank - 1'b1;
    meta_nxt[uway_c].rank = WAY_W'(WAYS - 1);
    if (hit_c) begin
      if (wr_r) meta_nxt[uway_c].dirty = 1'b1;
    end else begin
      meta_nxt[uway_c].tag   = tag_r;
      meta_nxt[uway_c].valid = 1'b1;
      meta_nxt[uway_c].dirty = wr_r;
    end
  end

  logic [LINE_W-1:0] line_c;
  assign line_c = {set_r, way_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_r == (MWORD_W+1)'(MEM_WORDS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (accept) state_nxt = ST_LOOKUP;
      ST_LOOKUP: begin
        if (hit_c) state_nxt = ST_DONE;
        else if (vdirty_c) state_nxt = ST_WB;
        else state_nxt = ST_FILL;
      end
      ST_WB:     if (cnt_r == (OFF_W+1)'(WORDS_PER_BLOCK)) state_nxt = ST_FILL;
      ST_FILL:   if (cnt_r == (OFF_W+1)'(WORDS_PER_BLOCK)) state_nxt = ST_DONE;
      ST_DONE:   if (!rd_pend_r) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Set memory write: zeroed during the clearing pass, updated on lookup.
  logic              sm_we;
  logic [SET_W-1:0]  sm_addr;
  set_meta_t         sm_wd;
  always_comb begin
    sm_we   = 1'b0;
    sm_addr = set_r;
    sm_wd   = meta_nxt;
    case (state_r)
      ST_CLEAR: begin
        sm_we   = 1'b1;
        sm_addr = clr_r[SET_W-1:0];
        sm_wd   = '0;
      end
      ST_LOOKUP: sm_we = 1'b1;
      default: ;
    endcase
  end

  // Memory addresses and enables.
  logic              lm_we, bm_we;
  logic [LWORD_W-1:0] lm_addr;
  logic [MWORD_W-1:0] bm_addr;
  logic [31:0]        lm_wd, bm_wd;
  logic [OFF_W-1:0]   cnt_w;
  logic               fill_we_ok;
  assign cnt_w = cnt_r[OFF_W-1:0];
  always_comb begin
    lm_we   = 1'b0;
    bm_we   = 1'b0;
    lm_addr = {line_c, off_r};
    bm_addr = {tag_r, set_r, cnt_w};
    lm_wd   = wdata_r;
    bm_wd   = line_q;
    fill_we_ok = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        bm_we   = 1'b1;
        bm_addr = clr_r[MWORD_W-1:0];
        bm_wd   = '0;
      end
      ST_WB: begin
        // Read the line word this cycle, write the previous one to the store.
        lm_addr = {line_c, cnt_w};
        bm_addr = {vtag_r, set_r, cnt_w - OFF_W'(1)};
        bm_we   = cnt_r != '0;
      end
      ST_FILL: begin
        // Read the store word this cycle, write the previous one to the line.
        bm_addr = {tag_r, set_r, cnt_w};
        lm_addr = {line_c, cnt_w - OFF_W'(1)};
        lm_wd   = (wr_r && (cnt_w - OFF_W'(1)) == off_r) ? wdata_r : back_q;
        lm_we   = cnt_r != '0;
        fill_we_ok = 1'b1;
      end
      ST_DONE: begin
        lm_addr = {line_c, off_r};
        lm_we   = rd_pend_r && wr_r && hit_r;
      end
      default: ;
    endcase
  end

  // Memory blocks.
  always_ff @(posedge clk) begin
    if (lm_we) line_mem[lm_addr] <= lm_wd;
    line_q <= line_mem[lm_addr];
  end
  always_ff @(posedge clk) begin
    if (bm_we) back_mem[bm_addr] <= bm_wd;
    back_q <= back_mem[bm_addr];
  end
  always_ff @(posedge clk) begin
    if (sm_we) set_mem[sm_addr] <= sm_wd;
    meta_q <= set_mem[blk_in[SET_W-1:0]];
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      cnt_r     <= '0;
      rd_pend_r <= 1'b0;
      hits_r    <= '0;
      miss_r    <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (out_rsp.valid && out_rsp.ready) ovalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (accept) begin
          wr_r    <= in_req.req_type;
          set_r   <= blk_in[SET_W-1:0];
          tag_r   <= TAG_W'(blk_in >> SET_W);
          off_r   <= in_req.word_offset[OFF_W-1:0];
          wdata_r <= in_req.write_data;
        end
        ST_LOOKUP: begin
          hit_r  <= hit_c;
          cnt_r  <= '0;
          way_r  <= uway_c;
          wb_r   <= hit_c ? 1'b0 : vdirty_c;
          vtag_r <= meta_q[vway_c].tag;
          if (hit_c) begin
            if (hits_r != '1) hits_r <= hits_r + 1'b1;
          end else begin
            if (miss_r != '1) miss_r <= miss_r + 1'b1;
          end
          rd_pend_r <= 1'b1;
        end
        ST_WB, ST_FILL: begin
          cnt_r <= (cnt_r == (OFF_W+1)'(WORDS_PER_BLOCK)) ? '0 : cnt_r + 1'b1;
        end
        ST_DONE: begin
          // With the read pending, issue the read of the addressed word; once it clears, take it.
          if (rd_pend_r) rd_pend_r <= 1'b0;
          else ovalid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result payload: a hit write returns the written word directly.
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && !rd_pend_r) begin
      ohit_r <= hit_r;
      owb_r  <= wb_r;
      oway_r <= 2'(way_r);
      oval_r <= (wr_r && hit_r) ? wdata_r : line_q;
    end
  end

  assign out_rsp.valid      = ovalid_r;
  assign out_rsp.hit        = ohit_r;
  assign out_rsp.word_value = oval_r;
  assign out_rsp.way_used   = oway_r;
  assign out_rsp.wrote_back = owb_r;
  assign out_rsp.hit_total  = hits_r;
  assign out_rsp.miss_total = miss_r;

  // Checks.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_LOOKUP) else $error("request taken while busy");
  a_wb_only_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> !(out_rsp.hit && out_rsp.wrote_back))
    else $error("write-back reported on a hit");
  a_not_ready_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_req.ready) else $error("ready during clearing pass");
  unused_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_we_ok |-> state_r == ST_FILL) else $error("fill write outside fill");
endmodule
